### rtl/core/rbes_pkg.sv
package rbes_pkg;

    // operation codes carried in tuser
    typedef enum logic [1:0] {
        OP_UPDATE  = 2'd0,
        OP_FORCE   = 2'd1,
        OP_IMPULSE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [1:0] CFG_MASS     = 2'd0;
    localparam logic [1:0] CFG_FRICTION = 2'd1;
    localparam logic [1:0] CFG_DRAG     = 2'd2;
    localparam logic [1:0] CFG_STATIC   = 2'd3;

    // time step fraction bits and fixed constants
    localparam int DT_BITS = 16;
    localparam logic signed [32:0] DRAG_K      = 33'sd1305047288;
    localparam logic signed [32:0] PIXEL_SCALE = 33'sd100;

    typedef logic signed [31:0] q_t;
    typedef logic signed [65:0] wide_t;

    // clamp a wide signed value into 32 bits
    function automatic q_t sat66(wide_t v);
        if (v > 66'sh7FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (v < -66'sh80000000) begin
            return -32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

### rtl/core/rigid_body_euler_step.sv
// rigid_body_euler_step: one 2D body integrated in signed fixed point
// s_ channel: one beat per command; tuser holds the operation (update,
// force, impulse, none), tdata holds time step, area and force/impulse vector.
// m_ channel: one beat per command with the full body state after it.
// cfg channel: register writes (mass, friction, drag mode, static flag),
// always ready; write only while the block is idle.
// one 33x33 multiplier and one restoring divider are shared under a
// sequencer; every product is registered in prod_reg before it is used.
// one command is in flight at a time, s_tready is high only while idle.
// reset clears position, velocity, acceleration, mass, friction and the
// static flag, and selects drag mode.
// while the receiver stalls the result beat holds and no command is taken.
module rigid_body_euler_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // time_step[15:0], cross_area, vec_x, vec_y
    input  logic [1:0]   s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // pos_x, pos_y, vel_x, vel_y, acc_x, acc_y
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_data
);
    import rbes_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW);
    localparam logic [CW-1:0] CNT_LAST = CW'(NW - 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_D_S, ST_D_S_W, ST_D_T, ST_D_T_W, ST_D_K, ST_D_K_W, ST_D_A,
        ST_D_DV, ST_D_DV_W, ST_D_H, ST_D_H_W, ST_D_M, ST_D_M_W, ST_D_P, ST_D_P_W,
        ST_E_AY, ST_E_V, ST_E_V_W, ST_E_P, ST_E_P_W, ST_FRIC, ST_F_M, ST_F_M_W,
        ST_F_D, ST_F_D_W, ST_V_START, ST_V_ADD, ST_DIV, ST_DIV_FIN, ST_DONE
    } state_t;

    state_t state_reg, ret_reg;
    q_t pos_reg [2];
    q_t vel_reg [2];
    q_t acc_reg [2];
    logic [31:0] mass_reg, fric_reg;
    logic drag_reg, static_reg;
    op_t op_reg;
    logic [15:0] dt_reg;
    logic [31:0] area_reg;
    q_t vec_reg [2];
    logic k_reg;
    q_t t0_reg, t1_reg, t2_reg, dq_reg;
    wide_t prod_reg;
    logic [NW-1:0] div_n_reg, div_q_reg;
    logic [31:0] rem_reg;
    logic div_neg_reg;
    logic [CW-1:0] cnt_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [32:0] dt_s;
    wide_t prod;
    q_t drag_c, div_x, a_in;
    logic [31:0] div_abs;
    logic [32:0] rem_sh;
    logic div_ge;
    logic signed [NW:0] q_signed;
    wide_t grav_w, half_w;

    assign dt_s = $signed({17'b0, dt_reg});

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_D_S: begin
                mul_a = 33'(vel_reg[1]);
                mul_b = vel_reg[1][31] ? -33'(vel_reg[1]) : 33'(vel_reg[1]);
            end
            ST_D_T: begin
                mul_a = $signed({1'b0, area_reg});
                mul_b = 33'(t0_reg);
            end
            ST_D_K: begin
                mul_a = 33'(t0_reg);
                mul_b = DRAG_K;
            end
            ST_D_DV: begin
                mul_a = 33'(t0_reg);
                mul_b = dt_s;
            end
            ST_D_H: begin
                mul_a = 33'(t1_reg);
                mul_b = dt_s;
            end
            ST_D_M: begin
                mul_a = 33'(vel_reg[1]);
                mul_b = dt_s;
            end
            ST_D_P: begin
                mul_a = 33'(t2_reg);
                mul_b = PIXEL_SCALE;
            end
            ST_E_V: begin
                mul_a = 33'(acc_reg[k_reg]);
                mul_b = dt_s;
            end
            ST_E_P: begin
                mul_a = 33'(vel_reg[k_reg]);
                mul_b = dt_s;
            end
            ST_F_M: begin
                mul_a = 33'(vel_reg[k_reg]);
                mul_b = $signed({1'b0, fric_reg});
            end
            ST_F_D: begin
                mul_a = 33'(t0_reg);
                mul_b = dt_s;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = 66'(mul_a) * 66'(mul_b);

    // drag term, divider source and divider step
    always_comb begin
        drag_c   = sat66(-(prod_reg >>> 32));
        div_x    = (state_reg == ST_D_K_W) ? drag_c : vec_reg[k_reg];
        div_abs  = div_x[31] ? 32'(-33'(div_x)) : div_x;
        rem_sh   = {rem_reg, div_n_reg[NW-1]};
        div_ge   = rem_sh >= {1'b0, mass_reg};
        q_signed = div_neg_reg ? -$signed({1'b0, div_q_reg}) : $signed({1'b0, div_q_reg});
        a_in     = (mass_reg != '0) ? dq_reg : '0;
        grav_w   = 66'(981) <<< FRAC_BITS;
        half_w   = 66'(9) <<< (FRAC_BITS - 1);
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_DONE);
    assign cfg_ready = 1'b1;
    assign m_tdata   = {acc_reg[1], acc_reg[0], vel_reg[1], vel_reg[0],
                        pos_reg[1], pos_reg[0]};

    // sequencer, body state and configuration
    always_ff @(posedge aclk) begin
        prod_reg <= prod;
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ret_reg    <= ST_IDLE;
            k_reg      <= 1'b0;
            pos_reg    <= '{default: '0};
            vel_reg    <= '{default: '0};
            acc_reg    <= '{default: '0};
            mass_reg   <= '0;
            fric_reg   <= '0;
            drag_reg   <= 1'b1;
            static_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_addr)
                    CFG_MASS:     mass_reg   <= cfg_data;
                    CFG_FRICTION: fric_reg   <= cfg_data;
                    CFG_DRAG:     drag_reg   <= cfg_data[0];
                    CFG_STATIC:   static_reg <= cfg_data[0];
                    default:      mass_reg   <= mass_reg;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg     <= op_t'(s_tuser);
                        dt_reg     <= s_tdata[15:0];
                        area_reg   <= s_tdata[47:16];
                        vec_reg[0] <= s_tdata[79:48];
                        vec_reg[1] <= s_tdata[111:80];
                        k_reg      <= 1'b0;
                        if (op_t'(s_tuser) == OP_UPDATE) begin
                            if (static_reg) state_reg <= ST_DONE;
                            else if (drag_reg) state_reg <= ST_D_S;
                            else state_reg <= ST_E_AY;
                        end else if ((op_t'(s_tuser) == OP_FORCE ||
                                      op_t'(s_tuser) == OP_IMPULSE) && mass_reg != '0) begin
                            state_reg <= ST_V_START;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                // drag integration on the vertical axis
                ST_D_S:   state_reg <= ST_D_S_W;
                ST_D_S_W: begin
                    t0_reg    <= sat66(prod_reg >>> FRAC_BITS);
                    state_reg <= ST_D_T;
                end
                ST_D_T:   state_reg <= ST_D_T_W;
                ST_D_T_W: begin
                    t0_reg    <= sat66(prod_reg >>> FRAC_BITS);
                    state_reg <= ST_D_K;
                end
                ST_D_K:   state_reg <= ST_D_K_W;
                ST_D_K_W: begin
                    if (mass_reg != '0) begin
                        div_neg_reg <= div_x[31];
                        div_n_reg   <= NW'(div_abs) << FRAC_BITS;
                        rem_reg     <= '0;
                        cnt_reg     <= '0;
                        ret_reg     <= ST_D_A;
                        state_reg   <= ST_DIV;
                    end else begin
                        state_reg   <= ST_D_A;
                    end
                end
                ST_D_A: begin
                    t0_reg    <= sat66(66'(a_in) + half_w);
                    state_reg <= ST_D_DV;
                end
                ST_D_DV:   state_reg <= ST_D_DV_W;
                ST_D_DV_W: begin
                    t1_reg    <= sat66(prod_reg >>> DT_BITS);
                    state_reg <= ST_D_H;
                end
                ST_D_H:   state_reg <= ST_D_H_W;
                ST_D_H_W: begin
                    t2_reg    <= sat66(prod_reg >>> (DT_BITS + 1));
                    state_reg <= ST_D_M;
                end
                ST_D_M:   state_reg <= ST_D_M_W;
                ST_D_M_W: begin
                    t2_reg    <= sat66(66'(sat66(prod_reg >>> DT_BITS)) + 66'(t2_reg));
                    state_reg <= ST_D_P;
                end
                ST_D_P:   state_reg <= ST_D_P_W;
                ST_D_P_W: begin
                    vel_reg[1] <= sat66(66'(vel_reg[1]) + 66'(t1_reg));
                    pos_reg[1] <= sat66(66'(pos_reg[1]) + 66'(sat66(prod_reg)));
                    state_reg  <= ST_FRIC;
                end
                // semi-implicit euler on both axes
                ST_E_AY: begin
                    acc_reg[1] <= sat66(66'(acc_reg[1]) + grav_w);
                    k_reg      <= 1'b0;
                    state_reg  <= ST_E_V;
                end
                ST_E_V:   state_reg <= ST_E_V_W;
                ST_E_V_W: begin
                    vel_reg[k_reg] <= sat66(66'(vel_reg[k_reg]) +
                                            66'(sat66(prod_reg >>> DT_BITS)));
                    state_reg <= ST_E_P;
                end
                ST_E_P:   state_reg <= ST_E_P_W;
                ST_E_P_W: begin
                    pos_reg[k_reg] <= sat66(66'(pos_reg[k_reg]) +
                                            66'(sat66(prod_reg >>> DT_BITS)));
                    if (k_reg) begin
                        acc_reg   <= '{default: '0};
                        state_reg <= ST_FRIC;
                    end else begin
                        k_reg     <= 1'b1;
                        state_reg <= ST_E_V;
                    end
                end
                // linear friction on both axes
                ST_FRIC: begin
                    k_reg     <= 1'b0;
                    state_reg <= (fric_reg != '0) ? ST_F_M : ST_DONE;
                end
                ST_F_M:   state_reg <= ST_F_M_W;
                ST_F_M_W: begin
                    t0_reg    <= sat66(-66'(sat66(prod_reg >>> FRAC_BITS)));
                    state_reg <= ST_F_D;
                end
                ST_F_D:   state_reg <= ST_F_D_W;
                ST_F_D_W: begin
                    vel_reg[k_reg] <= sat66(66'(vel_reg[k_reg]) +
                                            66'(sat66(prod_reg >>> DT_BITS)));
                    if (k_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        k_reg     <= 1'b1;
                        state_reg <= ST_F_M;
                    end
                end
                // force or impulse divided by mass
                ST_V_START: begin
                    div_neg_reg <= div_x[31];
                    div_n_reg   <= NW'(div_abs) << FRAC_BITS;
                    rem_reg     <= '0;
                    cnt_reg     <= '0;
                    ret_reg     <= ST_V_ADD;
                    state_reg   <= ST_DIV;
                end
                ST_V_ADD: begin
                    if (op_reg == OP_FORCE) begin
                        acc_reg[k_reg] <= sat66(66'(acc_reg[k_reg]) + 66'(dq_reg));
                    end else begin
                        vel_reg[k_reg] <= sat66(66'(vel_reg[k_reg]) + 66'(dq_reg));
                    end
                    if (k_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        k_reg     <= 1'b1;
                        state_reg <= ST_V_START;
                    end
                end
                // restoring divide, one quotient bit a cycle
                ST_DIV: begin
                    rem_reg   <= div_ge ? 32'(rem_sh - {1'b0, mass_reg}) : rem_sh[31:0];
                    div_q_reg <= {div_q_reg[NW-2:0], div_ge};
                    div_n_reg <= div_n_reg << 1;
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST) state_reg <= ST_DIV_FIN;
                end
                ST_DIV_FIN: begin
                    dq_reg    <= sat66(66'(q_signed));
                    state_reg <= ret_reg;
                end
                ST_DONE: begin
                    if (m_tready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // input and output sides are never open together
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // an accepted beat closes the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat accepted during work");

    // the divider only runs with a nonzero mass
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> mass_reg != '0)
        else $error("divide by zero mass");

    // a stalled result leaves the body state untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed under stall");
`endif

endmodule

### tb/sv/rigid_body_euler_step_checker.sv
`timescale 1ns / 100ps

module rigid_body_euler_step_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [191:0] m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           pending
);
    import rbes_pkg::*;

    // predicted body state and register copies
    q_t          body_pos [2];
    q_t          body_vel [2];
    q_t          body_acc [2];
    logic [31:0] mass_reg;
    logic [31:0] fric_reg;
    logic        drag_reg;
    logic        static_reg;

    logic [191:0] state_queue[$];

    assign pending = state_queue.size();

    function automatic q_t clamp(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return -32'sh80000000;
        return q_t'(v);
    endfunction

    // fixed products, arithmetic shift is a floor
    function automatic q_t fx_mul(longint a, longint b);
        longint p;
        p = a * b;
        return clamp(p >>> FRAC_BITS);
    endfunction

    function automatic q_t dt_mul(longint v, longint dt);
        longint p;
        p = v * dt;
        return clamp(p >>> DT_BITS);
    endfunction

    function automatic q_t mass_div(longint v);
        longint n;
        n = v * (64'sd1 << FRAC_BITS);
        return clamp(n / longint'({32'd0, mass_reg}));
    endfunction

    task automatic integrate(longint dt, longint area);
        longint vy, mag, prod;
        q_t s, t, drag, a_drag, a, dv, half, off, stp, f;
        if (static_reg) return;
        if (drag_reg) begin
            vy = body_vel[1];
            mag = vy < 0 ? -vy : vy;
            s = fx_mul(vy, mag);
            t = fx_mul(area, s);
            prod = longint'(t) * 64'sd1305047288;
            drag = clamp(-(prod >>> 32));
            a_drag = (mass_reg != 0) ? mass_div(drag) : 32'sd0;
            a = clamp(longint'(a_drag) + 64'sd9 * (64'sd1 << (FRAC_BITS - 1)));
            dv = dt_mul(a, dt);
            prod = longint'(dv) * dt;
            half = clamp(prod >>> (DT_BITS + 1));
            off = clamp(longint'(dt_mul(vy, dt)) + half);
            stp = clamp(longint'(off) * 100);
            body_vel[1] = clamp(vy + dv);
            body_pos[1] = clamp(longint'(body_pos[1]) + stp);
        end else begin
            body_acc[1] = clamp(longint'(body_acc[1]) + 64'sd981 * (64'sd1 << FRAC_BITS));
            for (int k = 0; k < 2; k++) begin
                body_vel[k] = clamp(longint'(body_vel[k]) + dt_mul(body_acc[k], dt));
                body_pos[k] = clamp(longint'(body_pos[k]) + dt_mul(body_vel[k], dt));
                body_acc[k] = 0;
            end
        end
        if (fric_reg != 0) begin
            for (int k = 0; k < 2; k++) begin
                f = clamp(-longint'(fx_mul(body_vel[k], longint'({32'd0, fric_reg}))));
                body_vel[k] = clamp(longint'(body_vel[k]) + dt_mul(f, dt));
            end
        end
    endtask

    task automatic apply_command(logic [1:0] op, logic [111:0] d);
        longint dt, area, vx, vy;
        dt = longint'({48'd0, d[15:0]});
        area = longint'({32'd0, d[47:16]});
        vx = longint'($signed(d[79:48]));
        vy = longint'($signed(d[111:80]));
        if (op == OP_UPDATE) begin
            integrate(dt, area);
        end else if (op == OP_FORCE && mass_reg != 0) begin
            body_acc[0] = clamp(longint'(body_acc[0]) + mass_div(vx));
            body_acc[1] = clamp(longint'(body_acc[1]) + mass_div(vy));
        end else if (op == OP_IMPULSE && mass_reg != 0) begin
            body_vel[0] = clamp(longint'(body_vel[0]) + mass_div(vx));
            body_vel[1] = clamp(longint'(body_vel[1]) + mass_div(vy));
        end
        state_queue.push_back({body_acc[1], body_acc[0], body_vel[1], body_vel[0],
                               body_pos[1], body_pos[0]});
    endtask

    // watch all three channels at each rising edge
    always @(posedge aclk) begin
        logic [191:0] want;
        if (!aresetn) begin
            for (int k = 0; k < 2; k++) begin
                body_pos[k] = 0;
                body_vel[k] = 0;
                body_acc[k] = 0;
            end
            mass_reg = 0;
            fric_reg = 0;
            drag_reg = 1'b1;
            static_reg = 1'b0;
            state_queue.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    CFG_MASS: begin
                        mass_reg = cfg_data;
                    end
                    CFG_FRICTION: begin
                        fric_reg = cfg_data;
                    end
                    CFG_DRAG: begin
                        drag_reg = cfg_data[0];
                    end
                    default: begin
                        static_reg = cfg_data[0];
                    end
                endcase
            end
            if (s_tvalid && s_tready) apply_command(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (state_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result beat %h", m_tdata);
                end else begin
                    want = state_queue.pop_front();
                    for (int k = 0; k < 6; k++) begin
                        if (m_tdata[32*k +: 32] !== want[32*k +: 32]) begin
                            fail_count++;
                            if (fail_count <= 10)
                                $display("field %0d: expected %h, got %h", k,
                                         want[32*k +: 32], m_tdata[32*k +: 32]);
                        end
                    end
                end
            end
        end
    end

endmodule

### tb/sv/rigid_body_euler_step_tb.sv
`timescale 1ns / 100ps

module rigid_body_euler_step_tb;
    import rbes_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;   // time_step[15:0], cross_area, vec_x, vec_y
    logic [1:0]   s_tuser;   // operation
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;   // pos_x, pos_y, vel_x, vel_y, acc_x, acc_y
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_addr;
    logic [31:0]  cfg_data;
    int           fail_count;
    int           pending;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_cycles;
    int           quiet_cycles;

    rigid_body_euler_step DUT (.*);

    rigid_body_euler_step_checker checker_inst (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver side: random stalls plus an optional long hold-off
    initial begin
        m_tready = 1'b0;
        hold_cycles = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles without any beat
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_cycles > 0)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_command(op_t op, logic [15:0] dt, logic [31:0] area,
                                logic [31:0] vx, logic [31:0] vy);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {vy, vx, area, dt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(32'h0002_0000);
            3: return -$urandom_range(32'h0002_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_commands(int n);
        op_t op;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: op = OP_UPDATE;
                5, 6: op = OP_FORCE;
                7, 8: op = OP_IMPULSE;
                default: op = OP_NONE;
            endcase
            send_command(op, $urandom_range(2) == 0 ? 16'($urandom) : 16'($urandom_range(3000)),
                         $urandom_range(1) ? $urandom : $urandom_range(32'h0004_0000),
                         rand_word(), rand_word());
        end
    endtask

    // one configuration phase: idle, write everything, then traffic
    task automatic run_phase(logic [31:0] mass, logic [31:0] fric, logic drag,
                             logic stat, int n);
        wait_drained();
        write_reg(CFG_MASS, mass);
        write_reg(CFG_FRICTION, fric);
        write_reg(CFG_DRAG, {31'd0, drag});
        write_reg(CFG_STATIC, {31'd0, stat});
        random_commands(n);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_UPDATE;
        cfg_valid = 1'b0;
        cfg_addr = CFG_MASS;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: reset registers, massless body with drag
        send_command(OP_UPDATE, 16'hFFFF, 32'hFFFFFFFF, 32'h0, 32'h0);
        send_command(OP_FORCE, 16'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000);
        send_command(OP_NONE, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        wait_drained();
        write_reg(CFG_MASS, 32'h0001_0000);
        send_command(OP_IMPULSE, 16'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000);
        send_command(OP_UPDATE, 16'hFFFF, 32'hFFFFFFFF, 32'h0, 32'h0);
        send_command(OP_UPDATE, 16'h8000, 32'h0001_0000, 32'h0, 32'h0);
        send_command(OP_FORCE, 16'h0, 32'h0, 32'h0003_0000, 32'hFFFD_0000);
        wait_drained();
        write_reg(CFG_DRAG, 32'd0);
        write_reg(CFG_FRICTION, 32'hFFFFFFFF);
        send_command(OP_UPDATE, 16'h0100, 32'h0, 32'h0, 32'h0);
        send_command(OP_IMPULSE, 16'h0, 32'h0, 32'h0100_0000, 32'hFF00_0000);
        send_command(OP_UPDATE, 16'hFFFF, 32'h0, 32'h0, 32'h0);
        wait_drained();
        write_reg(CFG_STATIC, 32'd1);
        send_command(OP_UPDATE, 16'hFFFF, 32'hFFFFFFFF, 32'h0, 32'h0);
        send_command(OP_FORCE, 16'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
        wait_drained();
        write_reg(CFG_MASS, 32'hFFFFFFFF);
        write_reg(CFG_STATIC, 32'd0);
        write_reg(CFG_FRICTION, 32'h1);
        send_command(OP_IMPULSE, 16'h0, 32'h0, 32'h80000000, 32'h7FFFFFFF);
        send_command(OP_UPDATE, 16'h0001, 32'h1, 32'h0, 32'h0);

        // random phases over settings and idling mixes
        run_phase(32'h0001_0000, 32'h0, 1'b1, 1'b0, 80);
        send_idle_pct = 45;
        run_phase(32'h0000_0001, 32'h0000_8000, 1'b0, 1'b0, 80);
        send_idle_pct = 0;
        recv_stall_pct = 45;
        run_phase($urandom_range(32'h0010_0000, 1), $urandom_range(32'h0004_0000), 1'b1,
                  1'b0, 80);
        send_idle_pct = 10;
        recv_stall_pct = 10;
        run_phase(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0, 80);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_phase(32'h0, $urandom, 1'b1, 1'b0, 60);
        run_phase($urandom, $urandom_range(32'h0002_0000), 1'b0, 1'b1, 40);

        // long receiver hold-off while commands keep coming
        hold_cycles = 600;
        run_phase(32'h0002_0000, 32'h0000_4000, 1'b0, 1'b0, 80);
        send_idle_pct = 45;
        recv_stall_pct = 45;
        run_phase($urandom, $urandom_range(32'h0001_0000), $urandom_range(1), 1'b0, 80);

        wait_drained();
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
